// ===== rtl/gb5_pkg.sv =====
// gb5_pkg: types, constants and arithmetic helpers for the 5x5 Gaussian blur core.
// Used by the interfaces and the top level; depends on nothing.
package gb5_pkg;

	localparam int KSIZE  = 5;
	localparam int CH_W   = 8;
	localparam int PIX_W  = 3 * CH_W;
	localparam int SLOTS  = 4;

	// configuration port
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 13;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
	localparam int FRAME_WIDTH_RST  = 640;
	localparam int FRAME_HEIGHT_RST = 480;
	localparam int MIN_SIZE         = 5;

	// kernel taps, symmetric
	localparam logic [KSIZE-1:0][2:0] TAPS = {3'd1, 3'd2, 3'd4, 3'd2, 3'd1};

	// (x + 50) / 100 as (x * 41944) >> 22, exact for x below 43690
	localparam int ROUND_BIAS = 50;
	localparam int DIV_MUL    = 41944;
	localparam int DIV_SHIFT  = 22;
	localparam int MUL_W      = 31;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [KSIZE-1:0][PIX_W-1:0] col_t;
	typedef logic [11:0] csum_t;
	typedef csum_t [KSIZE-1:0] csum_row_t;
	typedef logic [14:0] acc_t;
	typedef logic [CH_W-1:0] chan_t;

	function automatic csum_t col_sum(input col_t col, input logic [1:0] ch);
		csum_t acc;
		acc = '0;
		for (int r = 0; r < KSIZE; r++) begin
			acc = acc + csum_t'(TAPS[r]) * csum_t'(col[r][ch*CH_W +: CH_W]);
		end
		return acc;
	endfunction

	function automatic acc_t row_sum(input csum_row_t s);
		acc_t acc;
		acc = acc_t'(ROUND_BIAS);
		for (int c = 0; c < KSIZE; c++) begin
			acc = acc + acc_t'(TAPS[c]) * acc_t'(s[c]);
		end
		return acc;
	endfunction

	function automatic chan_t div100(input acc_t x);
		logic [MUL_W-1:0] prod;
		prod = MUL_W'(x) * MUL_W'(DIV_MUL);
		return prod[DIV_SHIFT +: CH_W];
	endfunction

endpackage

// ===== rtl/gb5_if.sv =====
// gb5_in_if / gb5_out_if: valid/ready pixel channels into and out of the blur core.
// Payload widths come from gb5_pkg.
interface gb5_in_if;
	logic                 valid;
	logic                 ready;
	logic [gb5_pkg::CH_W-1:0] blue_in;
	logic [gb5_pkg::CH_W-1:0] green_in;
	logic [gb5_pkg::CH_W-1:0] red_in;
	logic                 drain;

	modport source (output valid, blue_in, green_in, red_in, drain, input ready);
	modport sink   (input valid, blue_in, green_in, red_in, drain, output ready);
endinterface

interface gb5_out_if;
	logic                 valid;
	logic                 ready;
	logic [gb5_pkg::CH_W-1:0] blue_out;
	logic [gb5_pkg::CH_W-1:0] green_out;
	logic [gb5_pkg::CH_W-1:0] red_out;
	logic                 line_end;
	logic                 frame_end;

	modport source (output valid, blue_out, green_out, red_out, line_end, frame_end,
		input ready);
	modport sink   (input valid, blue_out, green_out, red_out, line_end, frame_end,
		output ready);
endinterface

// ===== rtl/gb5_ram.sv =====
// gb5_ram: simple dual-port RAM, one write port, one read port with registered data.
// Read data holds until the next read. No dependencies.
module gb5_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/gaussian_blur_5x5_stream_core.sv =====
// gaussian_blur_5x5_stream_core: streaming 5x5 BGR blur; depends on gb5_pkg, gb5_if, gb5_ram.
// Words pass the input, window, column-sum, kernel-sum and output registers in turn; 1 word
// per cycle unless pix_out.ready stalls, set by the single line-store RAM access (one read,
// one write per word). Frame output lags input by 2*width+2 words; drain words flush the tail.
// Reset (arst_n low) clears counters, valid flags, window and size registers
// (640 x 480); line-store contents stay undefined and are masked to zero until written.
module gaussian_blur_5x5_stream_core #(
	parameter int MAX_LINE_WIDTH   = 1024,
	parameter int MAX_FRAME_HEIGHT = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [gb5_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gb5_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	gb5_in_if.sink                            pix_in,
	gb5_out_if.source                         pix_out
);

	localparam int AW = $clog2(MAX_LINE_WIDTH);
	localparam int CW = $clog2(MAX_LINE_WIDTH + 1);
	localparam int HW = $clog2(MAX_FRAME_HEIGHT + 1);
	localparam int RW = $clog2(MAX_FRAME_HEIGHT + 3);
	localparam int LW = gb5_pkg::SLOTS * gb5_pkg::PIX_W;
	localparam int W_RST = (gb5_pkg::FRAME_WIDTH_RST > MAX_LINE_WIDTH) ?
		MAX_LINE_WIDTH : gb5_pkg::FRAME_WIDTH_RST;
	localparam int H_RST = (gb5_pkg::FRAME_HEIGHT_RST > MAX_FRAME_HEIGHT) ?
		MAX_FRAME_HEIGHT : gb5_pkg::FRAME_HEIGHT_RST;

	// size registers, held clamped
	logic [CW-1:0] w_q;
	logic [HW-1:0] h_q;
	logic [CW-1:0] w_clamp;
	logic [HW-1:0] h_clamp;
	int            w_val;
	int            h_val;

	// position of the next input word
	logic [AW-1:0] col_q;
	logic [RW-1:0] row_q;

	// handshake chain
	logic en1, en2, en3, en4, en5;
	logic accept, mv1, mv2, mv3, mv4;

	// stage 1: input word and line-store read
	logic             valid_s1;
	gb5_pkg::pix_t    pix_s1;
	logic             produce_s1;
	logic             border_s1;
	logic             line_end_s1;
	logic             frame_end_s1;
	logic [3:0]       mask_s1;
	logic [AW-1:0]    addr_s1;
	logic             fwd_s1;
	logic [LW-1:0]    fwd_data_s1;

	// stage 2: window
	logic                                      valid_s2;
	logic                                      border_s2;
	logic                                      line_end_s2;
	logic                                      frame_end_s2;
	gb5_pkg::col_t [gb5_pkg::KSIZE-1:0]        win_q;

	// stage 3: column sums
	logic                       valid_s3;
	logic                       border_s3;
	logic                       line_end_s3;
	logic                       frame_end_s3;
	gb5_pkg::pix_t              centre_s3;
	gb5_pkg::csum_row_t [2:0]   csum_s3;

	// stage 4: kernel sums
	logic                       valid_s4;
	logic                       border_s4;
	logic                       line_end_s4;
	logic                       frame_end_s4;
	gb5_pkg::pix_t              centre_s4;
	gb5_pkg::acc_t [2:0]        acc_s4;

	// stage 5: output word
	logic                       valid_s5;
	gb5_pkg::pix_t              pix_s5;
	logic                       line_end_s5;
	logic                       frame_end_s5;

	// position decode
	logic          last;
	logic          produce;
	logic          border;
	logic          line_end;
	logic          col_hi;
	logic [3:0]    mask;
	logic [RW-1:0] h_ext;

	// line store
	logic [LW-1:0]  rd_data;
	logic [LW-1:0]  line_word;
	logic [LW-1:0]  wr_data;
	gb5_pkg::col_t  new_col;

	assign en5 = !valid_s5 || pix_out.ready;
	assign en4 = !valid_s4 || en5;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign pix_in.ready = en1;
	assign accept = pix_in.valid && en1;
	assign mv1 = valid_s1 && en2;
	assign mv2 = valid_s2 && en3;
	assign mv3 = valid_s3 && en4;
	assign mv4 = valid_s4 && en5;

	always_comb begin
		w_val = int'(cfg_wdata[gb5_pkg::WIDTH_REG_W-1:0]);
		h_val = int'(cfg_wdata[gb5_pkg::HEIGHT_REG_W-1:0]);
		if (w_val < gb5_pkg::MIN_SIZE) begin
			w_clamp = CW'(gb5_pkg::MIN_SIZE);
		end else if (w_val > MAX_LINE_WIDTH) begin
			w_clamp = CW'(MAX_LINE_WIDTH);
		end else begin
			w_clamp = CW'(w_val);
		end
		if (h_val < gb5_pkg::MIN_SIZE) begin
			h_clamp = HW'(gb5_pkg::MIN_SIZE);
		end else if (h_val > MAX_FRAME_HEIGHT) begin
			h_clamp = HW'(MAX_FRAME_HEIGHT);
		end else begin
			h_clamp = HW'(h_val);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= CW'(W_RST);
			h_q <= HW'(H_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				gb5_pkg::REG_FRAME_WIDTH:  w_q <= w_clamp;
				gb5_pkg::REG_FRAME_HEIGHT: h_q <= h_clamp;
				default: ;
			endcase
		end
	end

	always_comb begin
		h_ext    = RW'(h_q);
		last     = (row_q > h_ext + RW'(2)) ||
			((row_q == h_ext + RW'(2)) && (col_q != '0));
		produce  = (row_q > RW'(2)) || ((row_q == RW'(2)) && (col_q >= AW'(2)));
		col_hi   = col_q >= AW'(2);
		border   = (col_q < AW'(4)) || (row_q < RW'(4)) || (row_q >= h_ext) ||
			(CW'(col_q) >= w_q);
		line_end = col_hi ? ({1'b0, CW'(col_q)} == ({1'b0, w_q} + (CW+1)'(1))) :
			(col_q == AW'(1));
		for (int j = 0; j < 4; j++) begin
			mask[j] = row_q >= RW'(4 - j);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (CW'(col_q) + CW'(1) >= w_q) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1       <= pix_in.drain ? '0 : {pix_in.red_in, pix_in.green_in, pix_in.blue_in};
			produce_s1   <= produce;
			border_s1    <= border;
			line_end_s1  <= line_end;
			frame_end_s1 <= last;
			mask_s1      <= mask;
			addr_s1      <= col_q;
			fwd_s1       <= mv1 && (addr_s1 == col_q);
			fwd_data_s1  <= wr_data;
		end
	end

	gb5_ram #(
		.WIDTH(LW),
		.DEPTH(MAX_LINE_WIDTH)
	) u_line_store (
		.clk  (clk),
		.we   (mv1),
		.waddr(addr_s1),
		.wdata(wr_data),
		.re   (accept),
		.raddr(col_q),
		.rdata(rd_data)
	);

	always_comb begin
		line_word = fwd_s1 ? fwd_data_s1 : rd_data;
		for (int j = 0; j < 4; j++) begin
			new_col[j] = mask_s1[j] ? line_word[j*gb5_pkg::PIX_W +: gb5_pkg::PIX_W] : '0;
		end
		new_col[4] = pix_s1;
		wr_data = {new_col[4], new_col[3], new_col[2], new_col[1]};
	end

	// stage 2: shift window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			win_q    <= '0;
		end else if (mv1) begin
			valid_s2 <= produce_s1;
			for (int c = 0; c < gb5_pkg::KSIZE - 1; c++) begin
				win_q[c] <= win_q[c+1];
			end
			win_q[gb5_pkg::KSIZE-1] <= new_col;
		end else if (en2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mv1) begin
			border_s2    <= border_s1;
			line_end_s2  <= line_end_s1;
			frame_end_s2 <= frame_end_s1;
		end
	end

	// stage 3: vertical sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (mv2) begin
			border_s3    <= border_s2;
			line_end_s3  <= line_end_s2;
			frame_end_s3 <= frame_end_s2;
			centre_s3    <= win_q[2][2];
			for (int ch = 0; ch < 3; ch++) begin
				for (int c = 0; c < gb5_pkg::KSIZE; c++) begin
					csum_s3[ch][c] <= gb5_pkg::col_sum(win_q[c], 2'(ch));
				end
			end
		end
	end

	// stage 4: horizontal sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (mv3) begin
			border_s4    <= border_s3;
			line_end_s4  <= line_end_s3;
			frame_end_s4 <= frame_end_s3;
			centre_s4    <= centre_s3;
			for (int ch = 0; ch < 3; ch++) begin
				acc_s4[ch] <= gb5_pkg::row_sum(csum_s3[ch]);
			end
		end
	end

	// stage 5: divide and select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en5) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (mv4) begin
			line_end_s5  <= line_end_s4;
			frame_end_s5 <= frame_end_s4;
			if (border_s4) begin
				pix_s5 <= centre_s4;
			end else begin
				pix_s5 <= {gb5_pkg::div100(acc_s4[2]), gb5_pkg::div100(acc_s4[1]),
					gb5_pkg::div100(acc_s4[0])};
			end
		end
	end

	assign pix_out.valid     = valid_s5;
	assign pix_out.blue_out  = pix_s5[0 +: gb5_pkg::CH_W];
	assign pix_out.green_out = pix_s5[gb5_pkg::CH_W +: gb5_pkg::CH_W];
	assign pix_out.red_out   = pix_s5[2*gb5_pkg::CH_W +: gb5_pkg::CH_W];
	assign pix_out.line_end  = line_end_s5;
	assign pix_out.frame_end = frame_end_s5;

endmodule

// ===== dv/gb5_blur_checker.sv =====
`timescale 1ns / 100ps
// gb5_blur_checker: watches the size registers and both pixel channels of the blur core,
// predicts every output word from the accepted input words and compares them in order.
// Depends on gb5_pkg and the channel interfaces in gb5_if.
module gb5_blur_checker #(
	parameter int MAX_LINE_WIDTH   = 1024,
	parameter int MAX_FRAME_HEIGHT = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [gb5_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gb5_pkg::CFG_DATA_W-1:0] cfg_wdata,
	gb5_in_if                              pix_in,
	gb5_out_if                             pix_out,
	output int                             mismatches,
	output int                             words_pending,
	output int                             words_checked
);

	localparam int unsigned KTAP [gb5_pkg::KSIZE] = '{1, 2, 4, 2, 1};
	localparam int unsigned KERNEL_SUM = 100;

	typedef struct packed {
		gb5_pkg::chan_t blue;
		gb5_pkg::chan_t green;
		gb5_pkg::chan_t red;
		logic           line_end;
		logic           frame_end;
	} blur_word_t;

	blur_word_t expected_words [$];

	logic [gb5_pkg::WIDTH_REG_W-1:0]  width_reg;
	logic [gb5_pkg::HEIGHT_REG_W-1:0] height_reg;
	gb5_pkg::pix_t line_mem [0:gb5_pkg::SLOTS*MAX_LINE_WIDTH-1];
	gb5_pkg::pix_t win [gb5_pkg::KSIZE][gb5_pkg::KSIZE];
	int unsigned col_pos;
	int unsigned row_pos;
	int unsigned item_pos;

	function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
		if (v < gb5_pkg::MIN_SIZE) return gb5_pkg::MIN_SIZE;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic gb5_pkg::chan_t blurred(input int sh);
		int unsigned acc;
		acc = 0;
		for (int c = 0; c < gb5_pkg::KSIZE; c++) begin
			for (int r = 0; r < gb5_pkg::KSIZE; r++) begin
				acc += KTAP[c] * KTAP[r] * win[c][r][sh +: gb5_pkg::CH_W];
			end
		end
		return gb5_pkg::chan_t'((acc + gb5_pkg::ROUND_BIAS) / KERNEL_SUM);
	endfunction

	function automatic void compare_field(input string field, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			mismatches++;
		end
	endfunction

	task automatic predict_word(input gb5_pkg::pix_t sample, output bit produced,
		output blur_word_t word);
		int unsigned w;
		int unsigned h;
		int unsigned total;
		int unsigned ocol;
		int orow;
		bit last;
		bit border;
		gb5_pkg::pix_t centre;
		gb5_pkg::pix_t fresh [gb5_pkg::KSIZE];
		w = clamp_size(width_reg, MAX_LINE_WIDTH);
		h = clamp_size(height_reg, MAX_FRAME_HEIGHT);
		total = w * h + 2 * w + 2;
		last = (item_pos + 1 >= total);

		// rows above the frame top read as zero
		for (int j = 0; j < gb5_pkg::SLOTS; j++) begin
			fresh[j] = '0;
			if (col_pos < MAX_LINE_WIDTH && row_pos + j >= gb5_pkg::SLOTS)
				fresh[j] = line_mem[j * MAX_LINE_WIDTH + col_pos];
		end
		fresh[gb5_pkg::KSIZE-1] = sample;
		if (col_pos < MAX_LINE_WIDTH) begin
			for (int j = 0; j < gb5_pkg::SLOTS; j++)
				line_mem[j * MAX_LINE_WIDTH + col_pos] = fresh[j + 1];
		end
		for (int c = 0; c < gb5_pkg::KSIZE - 1; c++) begin
			for (int j = 0; j < gb5_pkg::KSIZE; j++)
				win[c][j] = win[c + 1][j];
		end
		for (int j = 0; j < gb5_pkg::KSIZE; j++)
			win[gb5_pkg::KSIZE-1][j] = fresh[j];

		produced = 1'b0;
		word = '0;
		if (item_pos >= 2 * w + 2) begin
			if (col_pos >= 2) begin
				orow = int'(row_pos) - 2;
				ocol = col_pos - 2;
			end else begin
				orow = int'(row_pos) - 3;
				ocol = col_pos + w - 2;
			end
			border = orow < 2 || orow >= int'(h) - 2 || ocol < 2 || ocol >= w - 2;
			if (border) begin
				centre = win[2][2];
				word.blue  = centre[0 +: gb5_pkg::CH_W];
				word.green = centre[gb5_pkg::CH_W +: gb5_pkg::CH_W];
				word.red   = centre[2*gb5_pkg::CH_W +: gb5_pkg::CH_W];
			end else begin
				word.blue  = blurred(0);
				word.green = blurred(gb5_pkg::CH_W);
				word.red   = blurred(2 * gb5_pkg::CH_W);
			end
			word.line_end  = (ocol == w - 1);
			word.frame_end = last;
			produced = 1'b1;
		end

		if (last) begin
			item_pos = 0;
			col_pos = 0;
			row_pos = 0;
		end else begin
			item_pos++;
			if (col_pos + 1 >= w) begin
				col_pos = 0;
				row_pos++;
			end else begin
				col_pos++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		blur_word_t want;
		blur_word_t got;
		bit made;
		if (!arst_n) begin
			width_reg = gb5_pkg::WIDTH_REG_W'(gb5_pkg::FRAME_WIDTH_RST);
			height_reg = gb5_pkg::HEIGHT_REG_W'(gb5_pkg::FRAME_HEIGHT_RST);
			for (int c = 0; c < gb5_pkg::KSIZE; c++) begin
				for (int j = 0; j < gb5_pkg::KSIZE; j++)
					win[c][j] = '0;
			end
			col_pos = 0;
			row_pos = 0;
			item_pos = 0;
			expected_words.delete();
			mismatches = 0;
			words_checked = 0;
		end else begin
			if (pix_out.valid && pix_out.ready) begin
				got.blue      = pix_out.blue_out;
				got.green     = pix_out.green_out;
				got.red       = pix_out.red_out;
				got.line_end  = pix_out.line_end;
				got.frame_end = pix_out.frame_end;
				if (expected_words.size() == 0) begin
					$display("%0t: output word, expected none, got %p", $time, got);
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					compare_field("blue_out", want.blue, got.blue);
					compare_field("green_out", want.green, got.green);
					compare_field("red_out", want.red, got.red);
					compare_field("line_end", want.line_end, got.line_end);
					compare_field("frame_end", want.frame_end, got.frame_end);
					words_checked++;
				end
			end
			if (pix_in.valid && pix_in.ready) begin
				predict_word(pix_in.drain ? gb5_pkg::pix_t'(0)
					: {pix_in.red_in, pix_in.green_in, pix_in.blue_in}, made, want);
				if (made)
					expected_words.push_back(want);
			end
			if (cfg_we) begin
				case (cfg_index)
					gb5_pkg::REG_FRAME_WIDTH:
						width_reg = cfg_wdata[gb5_pkg::WIDTH_REG_W-1:0];
					gb5_pkg::REG_FRAME_HEIGHT:
						height_reg = cfg_wdata[gb5_pkg::HEIGHT_REG_W-1:0];
					default: ;
				endcase
			end
		end
		words_pending = expected_words.size();
	end

endmodule

// ===== dv/tb_gaussian_blur_5x5_stream_core.sv =====
`timescale 1ns / 100ps
// tb_gaussian_blur_5x5_stream_core: drives frames, drain words and size settings into the
// blur core with random idling on both channels; gb5_blur_checker predicts and compares.
// Depends on gb5_pkg, gb5_if, the core and gb5_blur_checker.
module tb_gaussian_blur_5x5_stream_core;

	localparam int MAX_W      = 1024;
	localparam int MAX_H      = 4096;
	localparam int LONG_HOLD  = 400;
	localparam int SETTLE     = 12;
	localparam int RANDOM_ITEMS = 200;
	localparam int CFG_W      = gb5_pkg::CFG_DATA_W;

	typedef enum int {FRAME_RANDOM, FRAME_BRIGHT, FRAME_ROUNDING} frame_kind_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [gb5_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]               cfg_wdata;

	int mismatches;
	int words_pending;
	int words_checked;

	bit quiet;
	int hold_requests;
	int holds_done;
	int frames_sent;
	int settings_used;
	int unsigned cur_w;
	int unsigned cur_h;

	gb5_in_if  pix_in ();
	gb5_out_if pix_out ();

	gaussian_blur_5x5_stream_core #(
		.MAX_LINE_WIDTH   (MAX_W),
		.MAX_FRAME_HEIGHT (MAX_H)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pix_in    (pix_in),
		.pix_out   (pix_out)
	);

	gb5_blur_checker #(
		.MAX_LINE_WIDTH   (MAX_W),
		.MAX_FRAME_HEIGHT (MAX_H)
	) blur_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.pix_in        (pix_in),
		.pix_out       (pix_out),
		.mismatches    (mismatches),
		.words_pending (words_pending),
		.words_checked (words_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int unsigned effective_size(input int unsigned raw, input int unsigned hi);
		if (raw < gb5_pkg::MIN_SIZE) return gb5_pkg::MIN_SIZE;
		if (raw > hi) return hi;
		return raw;
	endfunction

	task automatic write_sizes(input logic [CFG_W-1:0] raw_w, input logic [CFG_W-1:0] raw_h);
		cfg_we <= 1'b1;
		cfg_index <= gb5_pkg::REG_FRAME_WIDTH;
		cfg_wdata <= raw_w;
		@(negedge clk);
		cfg_index <= gb5_pkg::REG_FRAME_HEIGHT;
		cfg_wdata <= raw_h;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_w = effective_size(raw_w[gb5_pkg::WIDTH_REG_W-1:0], MAX_W);
		cur_h = effective_size(raw_h[gb5_pkg::HEIGHT_REG_W-1:0], MAX_H);
		settings_used++;
	endtask

	task automatic send_word(input gb5_pkg::pix_t value, input logic flush);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			pix_in.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		pix_in.valid    <= 1'b1;
		pix_in.blue_in  <= value[0 +: gb5_pkg::CH_W];
		pix_in.green_in <= value[gb5_pkg::CH_W +: gb5_pkg::CH_W];
		pix_in.red_in   <= value[2*gb5_pkg::CH_W +: gb5_pkg::CH_W];
		pix_in.drain    <= flush;
		@(posedge clk);
		while (!pix_in.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		pix_in.valid <= 1'b0;
		while (words_pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic send_frame(input frame_kind_t kind);
		int unsigned n_pix;
		int unsigned n_all;
		gb5_pkg::pix_t value;
		logic flush;
		n_pix = cur_w * cur_h;
		n_all = n_pix + 2 * cur_w + 2;
		for (int unsigned k = 0; k < n_all; k++) begin
			value = gb5_pkg::pix_t'($urandom);
			flush = (k >= n_pix);
			case (kind)
				FRAME_RANDOM: begin
					flush = (k >= n_pix) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 31) == 0);
				end
				FRAME_BRIGHT: begin
					if (k < n_pix) value = '1;
				end
				FRAME_ROUNDING: begin
					// one corner pixel sets the rounding of the sole blurred centre
					if (k == 0) value = {8'd255, 8'd49, 8'd50};
					else if (k == 7) flush = 1'b1;
					else if (k == n_pix) flush = 1'b0;
					else if (k < n_pix) value = '0;
					// hold mid-frame until every due word is out
					if (k == n_pix - 3) begin
						pix_in.valid <= 1'b0;
						while (words_pending != 0) @(negedge clk);
					end
				end
				default: ;
			endcase
			send_word(value, flush);
		end
		frames_sent++;
	endtask

	initial begin : sink_side
		pix_out.ready = 1'b0;
		holds_done = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (holds_done != hold_requests) begin
				holds_done++;
				pix_out.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				pix_out.ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				pix_out.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
				pix_out.ready <= 1'b1;
			end else begin
				pix_out.ready <= 1'b1;
			end
		end
	end

	initial begin : source_side
		int random_items;
		logic [CFG_W-1:0] raw_w;
		logic [CFG_W-1:0] raw_h;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = gb5_pkg::REG_FRAME_WIDTH;
		cfg_wdata = '0;
		pix_in.valid = 1'b0;
		pix_in.blue_in = '0;
		pix_in.green_in = '0;
		pix_in.red_in = '0;
		pix_in.drain = 1'b0;
		quiet = 1'b0;
		hold_requests = 0;
		frames_sent = 0;
		settings_used = 0;
		random_items = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_sizes(13'd5, 13'd5);
		send_frame(FRAME_ROUNDING);
		wait_idle();
		send_frame(FRAME_BRIGHT);
		wait_idle();

		// sizes below the minimum clamp up
		write_sizes(13'd0, 13'd2);
		send_frame(FRAME_RANDOM);
		wait_idle();

		// stall the output long enough to back the core up
		write_sizes(13'd12, 13'd8);
		hold_requests++;
		send_frame(FRAME_RANDOM);
		wait_idle();

		while (random_items < RANDOM_ITEMS) begin
			if (random_items > RANDOM_ITEMS - 100) quiet = 1'b1;
			raw_w = ($urandom_range(0, 5) == 0) ? CFG_W'($urandom_range(0, 4))
				: CFG_W'($urandom_range(5, 12));
			raw_h = ($urandom_range(0, 5) == 0) ? CFG_W'($urandom_range(0, 4))
				: CFG_W'($urandom_range(5, 10));
			if ($urandom_range(0, 7) == 0) raw_w = raw_w | 13'h1800;
			write_sizes(raw_w, raw_h);
			repeat ($urandom_range(1, 3)) begin
				if (random_items < RANDOM_ITEMS) begin
					send_frame(FRAME_RANDOM);
					random_items += int'(cur_w * cur_h + 2 * cur_w + 2);
				end
			end
			wait_idle();
		end

		$display("Run covered %0d frames over %0d size settings, %0d output words checked.",
			frames_sent, settings_used, words_checked);
		$display("Included sizes clamped up, rounding, drain and flush cases, a long stall.");
		if (mismatches == 0 && words_pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
